>>> rtl/core/kfmpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kfmpt_pkg: shared types and constants
// Payload structs, configuration indexes, sequencer states and the arctangent
// table used by the keyframe motion point transform.
// ----------------------------------------------------------------------------
package kfmpt_pkg;

  typedef struct packed {
    logic               mode;
    logic [5:0]         key_slot;
    logic [31:0]        sample_time;
    logic signed [31:0] shift_x;
    logic signed [31:0] shift_y;
    logic signed [31:0] shift_z;
    logic signed [15:0] angle_x;
    logic signed [15:0] angle_y;
    logic signed [15:0] angle_z;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] moved_x;
    logic signed [31:0] moved_y;
    logic signed [31:0] moved_z;
  } out_item_t;

  localparam logic [1:0] CFG_ORIGIN_X = 2'd0;
  localparam logic [1:0] CFG_ORIGIN_Y = 2'd1;
  localparam logic [1:0] CFG_ORIGIN_Z = 2'd2;
  localparam logic [1:0] CFG_KEYS     = 2'd3;

  localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;
  localparam int unsigned        CORDIC_GUARD    = 8;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN,
    ST_FRAC_RD,
    ST_FRAC_LD,
    ST_DIV,
    ST_LERP_RD,
    ST_LERP_LD,
    ST_LERP_ADD,
    ST_ROT_SETUP,
    ST_ROT_MUL,
    ST_ROT_PRE,
    ST_ROT_ITER,
    ST_ROT_DONE,
    ST_SUM,
    ST_OUT
  } state_e;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000; 5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B; 5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43; 5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E; 5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53; 5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA; 5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C; 5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029; 5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A; 5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003; 5'd29: r = 32'h00000001;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/kfmpt_key_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kfmpt_key_mem: keyframe table
// One write port and one registered read port holding time, shift and angles.
// ----------------------------------------------------------------------------
module kfmpt_key_mem #(
  parameter int unsigned MAX_KEYS = 64,
  localparam int unsigned AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1,
  localparam int unsigned KW = 32 * 4 + 16 * 3
) (
  input  wire logic          clk_i,
  input  wire logic          wr_en_i,
  input  wire logic [AW-1:0] wr_addr_i,
  input  wire logic [KW-1:0] wr_data_i,
  input  wire logic [AW-1:0] rd_addr_i,
  output logic      [KW-1:0] rd_data_o
);

  logic [KW-1:0] mem_q [MAX_KEYS];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule
`default_nettype wire

>>> rtl/core/kfmpt_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kfmpt_alu: shared arithmetic unit
// A registered 34x34 signed multiplier and a 66-bit adder shared by the
// interpolation, prescale, CORDIC and summing steps.
// ----------------------------------------------------------------------------
module kfmpt_alu (
  input  wire logic               clk_i,
  input  wire logic signed [33:0] mul_a_i,
  input  wire logic signed [33:0] mul_b_i,
  input  wire logic signed [65:0] add_a_i,
  input  wire logic signed [65:0] add_b_i,
  input  wire logic               sub_i,
  output logic signed [67:0]      prod_o,
  output logic signed [65:0]      sum_o
);

  always_ff @(posedge clk_i) begin
    prod_o <= mul_a_i * mul_b_i;
  end

  assign sum_o = sub_i ? (add_a_i - add_b_i) : (add_a_i + add_b_i);

endmodule
`default_nettype wire

>>> rtl/core/kfmpt_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kfmpt_divider: restoring divider
// 48-bit by 32-bit unsigned division, one quotient bit a cycle, 17-bit result
// (the numerator stays below 65536 times the denominator).
// ----------------------------------------------------------------------------
module kfmpt_divider (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] num_i,
  input  wire logic [31:0] den_i,
  output logic             done_o,
  output logic [16:0]      quot_o
);

  logic [32:0] rem_q, rem_d;
  logic [47:0] num_q, num_d;
  logic [31:0] den_q;
  logic [16:0] quot_q, quot_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [33:0] trial;

  always_comb begin
    rem_d  = rem_q;
    num_d  = num_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q, num_q[47]} - {2'b00, den_q};
    if (start_i) begin
      rem_d  = '0;
      num_d  = {num_i, 16'h0};
      quot_d = '0;
      cnt_d  = 6'd48;
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[46:0], 1'b0};
      if (!trial[33]) begin
        rem_d  = trial[32:0];
        quot_d = {quot_q[15:0], 1'b1};
      end else begin
        rem_d  = {rem_q[31:0], num_q[47]};
        quot_d = {quot_q[15:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    num_q  <= num_d;
    quot_q <= quot_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = busy_q && (cnt_q == 6'd1);
  assign quot_o = quot_d;

endmodule
`default_nettype wire

>>> rtl/core/keyframe_motion_point_transform_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keyframe_motion_point_transform_unit: keyframe motion point transform
// Keyframe table, interval search, fraction division, linear interpolation and
// three CORDIC rotations about the origin, on one shared unit and a divider.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake               | payload
//  in       | in  | in_valid_i / in_ready_o  | in_item_i  (kfmpt_pkg::in_item_t)
//  out      | out | out_valid_o/ out_ready_i | out_item_o (kfmpt_pkg::out_item_t)
//  cfg      | in  | cfg_valid_i/ cfg_ready_o | cfg_index_i, cfg_data_i
//
// A keyframe write is done in ST_IDLE. A transform runs a table scan, fetches
// the interval and divides for the fraction, interpolates six values, rotates
// about each axis (skipped for a zero angle) and sums, one step at a time on
// the sequencer and its single multiplier.
// Reset clears control and loads the registers with their reset values.
// in_ready_o is low from acceptance of a transform until the result is taken.
// ----------------------------------------------------------------------------
module keyframe_motion_point_transform_unit #(
  parameter int unsigned MAX_KEYS     = 64,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire kfmpt_pkg::in_item_t  in_item_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output kfmpt_pkg::out_item_t      out_item_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [1:0]           cfg_index_i,
  input  wire logic [31:0]          cfg_data_i
);

  localparam int unsigned AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int unsigned NW = $clog2(MAX_KEYS + 1);
  localparam int unsigned KW = 32 * 4 + 16 * 3;
  localparam int unsigned STEPS = (CORDIC_STEPS < 30) ? CORDIC_STEPS : 30;
  localparam int unsigned CG = kfmpt_pkg::CORDIC_GUARD;

  kfmpt_pkg::state_e state_q, state_d;

  logic signed [31:0] org_q [3];
  logic [6:0]         keys_q;
  kfmpt_pkg::in_item_t item_q;

  // key read port
  logic          wr_en;
  logic [AW-1:0] rd_addr;
  logic [KW-1:0] rd_data;
  logic [31:0]   rd_time;
  logic signed [31:0] rd_val [6];

  kfmpt_key_mem #(.MAX_KEYS(MAX_KEYS)) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (in_item_i.key_slot[AW-1:0]),
    .wr_data_i ({in_item_i.sample_time, in_item_i.shift_x, in_item_i.shift_y,
                 in_item_i.shift_z, in_item_i.angle_x, in_item_i.angle_y,
                 in_item_i.angle_z}),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign rd_time   = rd_data[175:144];
  assign rd_val[0] = rd_data[143:112];
  assign rd_val[1] = rd_data[111:80];
  assign rd_val[2] = rd_data[79:48];
  assign rd_val[3] = {{16{rd_data[47]}}, rd_data[47:32]};
  assign rd_val[4] = {{16{rd_data[31]}}, rd_data[31:16]};
  assign rd_val[5] = {{16{rd_data[15]}}, rd_data[15:0]};

  // sequencer registers
  logic [NW-1:0] n_q, n_d;
  logic [NW-1:0] idx_q, idx_d;
  logic [AW-1:0] lo_q, lo_d;
  logic [31:0]   t0_q, t0_d;
  logic          first_q, first_d;
  logic [16:0]   f_q, f_d;
  logic [2:0]    k_q, k_d;
  logic          sel_q, sel_d;
  logic signed [31:0] va_q, va_d;
  logic signed [31:0] interp_q [6];
  logic signed [31:0] interp_d [6];
  logic signed [65:0] p_q [3];
  logic signed [65:0] p_d [3];
  logic [1:0]    axis_q, axis_d;
  logic [4:0]    it_q, it_d;
  logic signed [31:0] zr_q, zr_d;
  logic signed [65:0] ra_q, ra_d, rb_q, rb_d;
  logic          ph_q, ph_d;
  kfmpt_pkg::out_item_t res_q, res_d;

  // shared unit
  logic signed [33:0] mul_a, mul_b;
  logic signed [65:0] add_a, add_b;
  logic               add_sub;
  logic signed [67:0] prod;
  logic signed [65:0] sum;

  kfmpt_alu u_alu (
    .clk_i   (clk_i),
    .mul_a_i (mul_a),
    .mul_b_i (mul_b),
    .add_a_i (add_a),
    .add_b_i (add_b),
    .sub_i   (add_sub),
    .prod_o  (prod),
    .sum_o   (sum)
  );

  logic        div_start, div_done;
  logic [31:0] div_num, div_den;
  logic [16:0] div_q;

  kfmpt_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_q)
  );

  // rotation axis pairs: x uses (y,z), y uses (z,x), z uses (x,y)
  logic [1:0] u_sel, v_sel;
  logic signed [31:0] ang;
  logic signed [65:0] sh_a, sh_b;
  logic [31:0] atn;

  always_comb begin
    case (axis_q)
      2'd0:    begin u_sel = 2'd1; v_sel = 2'd2; end
      2'd1:    begin u_sel = 2'd2; v_sel = 2'd0; end
      default: begin u_sel = 2'd0; v_sel = 2'd1; end
    endcase
  end

  always_comb begin
    case (axis_q)
      2'd0:    ang = interp_q[3];
      2'd1:    ang = interp_q[4];
      default: ang = interp_q[5];
    endcase
  end

  assign sh_a = ra_q >>> it_q;
  assign sh_b = rb_q >>> it_q;
  assign atn  = kfmpt_pkg::atan_turn(it_q);

  logic [6:0] n_raw;
  assign n_raw = keys_q;

  logic signed [65:0] sat_in;
  logic signed [31:0] sat_out;
  always_comb begin
    sat_in = sum;
    if (sum > 66'sd2147483647) begin
      sat_out = 32'sh7FFFFFFF;
    end else if (sum < -66'sd2147483648) begin
      sat_out = 32'sh80000000;
    end else begin
      sat_out = sat_in[31:0];
    end
  end

  always_comb begin
    state_d   = state_q;
    n_d = n_q; idx_d = idx_q; lo_d = lo_q; t0_d = t0_q; first_d = first_q;
    f_d = f_q; k_d = k_q; sel_d = sel_q; va_d = va_q;
    interp_d  = interp_q;
    p_d       = p_q;
    axis_d = axis_q; it_d = it_q; zr_d = zr_q; ra_d = ra_q; rb_d = rb_q;
    ph_d = ph_q;
    res_d     = res_q;
    wr_en     = 1'b0;
    rd_addr   = idx_q[AW-1:0];
    mul_a     = '0;
    mul_b     = '0;
    add_a     = '0;
    add_b     = '0;
    add_sub   = 1'b0;
    div_start = 1'b0;
    div_num   = item_q.sample_time - t0_q;
    div_den   = rd_time - t0_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;

    case (state_q)
      kfmpt_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (!in_item_i.mode) begin
            wr_en = ({26'd0, in_item_i.key_slot} < MAX_KEYS);
          end else begin
            if (n_raw < 7'd2) begin
              n_d = NW'(2);
            end else if (32'(n_raw) > MAX_KEYS) begin
              n_d = NW'(MAX_KEYS);
            end else begin
              n_d = NW'(n_raw);
            end
            idx_d   = '0;
            lo_d    = '0;
            first_d = 1'b1;
            state_d = kfmpt_pkg::ST_SCAN_RD;
          end
        end
      end
      // walk key times 0..n-1; lo is the last i<=n-2 with time<=t
      kfmpt_pkg::ST_SCAN_RD: begin
        state_d = kfmpt_pkg::ST_SCAN;
      end
      kfmpt_pkg::ST_SCAN: begin
        if (first_q) begin
          first_d = 1'b0;
          if (item_q.sample_time <= rd_time) begin
            lo_d = '0; f_d = '0;
            state_d = kfmpt_pkg::ST_LERP_RD;
          end
        end
        if (state_d == kfmpt_pkg::ST_SCAN) begin
          if (idx_q == n_q - NW'(1)) begin
            if (item_q.sample_time >= rd_time) begin
              lo_d = AW'(n_q - NW'(2));
              f_d  = 17'h10000;
              state_d = kfmpt_pkg::ST_LERP_RD;
            end else begin
              state_d = kfmpt_pkg::ST_FRAC_RD;
            end
          end else begin
            if (rd_time <= item_q.sample_time) begin
              lo_d = idx_q[AW-1:0];
            end
            idx_d   = idx_q + NW'(1);
            rd_addr = AW'(idx_q + NW'(1));
            state_d = kfmpt_pkg::ST_SCAN;
          end
        end
        if (state_d == kfmpt_pkg::ST_SCAN) begin
          rd_addr = AW'(idx_q + NW'(1));
        end
      end
      kfmpt_pkg::ST_FRAC_RD: begin
        rd_addr = lo_q;
        state_d = kfmpt_pkg::ST_FRAC_LD;
        sel_d   = 1'b0;
      end
      kfmpt_pkg::ST_FRAC_LD: begin
        if (!sel_q) begin
          t0_d    = rd_time;
          rd_addr = lo_q + AW'(1);
          sel_d   = 1'b1;
        end else if (item_q.sample_time >= rd_time) begin
          f_d     = 17'h10000;
          state_d = kfmpt_pkg::ST_LERP_RD;
        end else begin
          div_start = 1'b1;
          state_d   = kfmpt_pkg::ST_DIV;
        end
      end
      kfmpt_pkg::ST_DIV: begin
        if (div_done) begin
          f_d     = div_q;
          state_d = kfmpt_pkg::ST_LERP_RD;
        end
      end
      // interp: a + floor((b-a)*f/65536), six values, a and b read in turn
      kfmpt_pkg::ST_LERP_RD: begin
        rd_addr = lo_q;
        k_d     = '0;
        sel_d   = 1'b0;
        state_d = kfmpt_pkg::ST_LERP_LD;
      end
      kfmpt_pkg::ST_LERP_LD: begin
        if (!sel_q) begin
          va_d    = rd_val[k_q];
          rd_addr = lo_q + AW'(1);
          sel_d   = 1'b1;
        end else begin
          mul_a   = 34'(signed'(rd_val[k_q])) - 34'(va_q);
          mul_b   = {17'd0, f_q};
          state_d = kfmpt_pkg::ST_LERP_ADD;
        end
      end
      kfmpt_pkg::ST_LERP_ADD: begin
        add_a = 66'(va_q);
        add_b = 66'(prod >>> 16);
        interp_d[k_q] = sum[31:0];
        rd_addr = lo_q;
        sel_d   = 1'b0;
        if (k_q == 3'd5) begin
          p_d[0] = 66'(signed'(item_q.point_x)) - 66'(org_q[0]);
          p_d[1] = 66'(signed'(item_q.point_y)) - 66'(org_q[1]);
          p_d[2] = 66'(signed'(item_q.point_z)) - 66'(org_q[2]);
          axis_d  = 2'd0;
          state_d = kfmpt_pkg::ST_ROT_SETUP;
        end else begin
          k_d     = k_q + 3'd1;
          state_d = kfmpt_pkg::ST_LERP_LD;
        end
      end
      // rotation: prescale both components by the gain, then CORDIC steps
      kfmpt_pkg::ST_ROT_SETUP: begin
        if (ang == 32'sd0) begin
          if (axis_q == 2'd2) begin
            state_d = kfmpt_pkg::ST_SUM;
            k_d     = '0;
          end else begin
            axis_d = axis_q + 2'd1;
          end
        end else begin
          zr_d    = {ang[15:0], 16'h0};
          mul_a   = p_q[u_sel][33:0];
          mul_b   = 34'(kfmpt_pkg::CORDIC_GAIN_Q30);
          ph_d    = 1'b0;
          state_d = kfmpt_pkg::ST_ROT_MUL;
        end
      end
      kfmpt_pkg::ST_ROT_MUL: begin
        // v operand held in both ST_ROT_MUL phases so its product is there in ST_ROT_PRE
        mul_a = p_q[v_sel][33:0];
        mul_b = 34'(kfmpt_pkg::CORDIC_GAIN_Q30);
        if (!ph_q) begin
          ra_d  = 66'(prod >>> (30 - CG));
          ph_d  = 1'b1;
        end else begin
          state_d = kfmpt_pkg::ST_ROT_PRE;
        end
      end
      kfmpt_pkg::ST_ROT_PRE: begin
        rb_d = 66'(prod >>> (30 - CG));
        // beyond a quarter turn: negate and take off a half turn
        if (ang > 32'sd16384 || ang < -32'sd16384) begin
          ra_d = -ra_q;
          rb_d = -66'(prod >>> (30 - CG));
          zr_d = zr_q ^ 32'h80000000;
        end
        it_d    = '0;
        state_d = kfmpt_pkg::ST_ROT_ITER;
      end
      kfmpt_pkg::ST_ROT_ITER: begin
        add_a   = ra_q;
        add_b   = sh_b;
        add_sub = !zr_q[31];
        ra_d    = sum;
        if (!zr_q[31]) begin
          rb_d = rb_q + sh_a;
          zr_d = zr_q - atn;
        end else begin
          rb_d = rb_q - sh_a;
          zr_d = zr_q + atn;
        end
        it_d = it_q + 5'd1;
        if (32'(it_q) == STEPS - 1) begin
          state_d = kfmpt_pkg::ST_ROT_DONE;
        end
      end
      kfmpt_pkg::ST_ROT_DONE: begin
        p_d[u_sel] = (ra_q + 66'(1 << (CG - 1))) >>> CG;
        p_d[v_sel] = (rb_q + 66'(1 << (CG - 1))) >>> CG;
        if (axis_q == 2'd2) begin
          k_d     = '0;
          state_d = kfmpt_pkg::ST_SUM;
        end else begin
          axis_d  = axis_q + 2'd1;
          state_d = kfmpt_pkg::ST_ROT_SETUP;
        end
      end
      kfmpt_pkg::ST_SUM: begin
        add_a = p_q[k_q[1:0]];
        add_b = 66'(org_q[k_q[1:0]]) + 66'(interp_q[k_q]);
        case (k_q)
          3'd0:    res_d.moved_x = sat_out;
          3'd1:    res_d.moved_y = sat_out;
          default: res_d.moved_z = sat_out;
        endcase
        k_d = k_q + 3'd1;
        if (k_q == 3'd2) begin
          state_d = kfmpt_pkg::ST_OUT;
        end
      end
      kfmpt_pkg::ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = kfmpt_pkg::ST_IDLE;
        end
      end
      default: state_d = kfmpt_pkg::ST_IDLE;
    endcase
  end

  assign cfg_ready_o = 1'b1;
  assign out_item_o  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= kfmpt_pkg::ST_IDLE;
      org_q[0] <= '0;
      org_q[1] <= '0;
      org_q[2] <= '0;
      keys_q   <= 7'd2;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          kfmpt_pkg::CFG_ORIGIN_X: org_q[0] <= cfg_data_i;
          kfmpt_pkg::CFG_ORIGIN_Y: org_q[1] <= cfg_data_i;
          kfmpt_pkg::CFG_ORIGIN_Z: org_q[2] <= cfg_data_i;
          kfmpt_pkg::CFG_KEYS:     keys_q   <= cfg_data_i[6:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
    n_q <= n_d; idx_q <= idx_d; lo_q <= lo_d; t0_q <= t0_d; first_q <= first_d;
    f_q <= f_d; k_q <= k_d; sel_q <= sel_d; va_q <= va_d;
    interp_q <= interp_d;
    p_q      <= p_d;
    axis_q <= axis_d; it_q <= it_d; zr_q <= zr_d; ra_q <= ra_d; rb_q <= rb_d;
    ph_q   <= ph_d;
    res_q  <= res_d;
  end

endmodule
`default_nettype wire
